[hw/rtl/mah_pkg.sv]
// ---------------------------------------------------------------------------
// mah_pkg
// Shared types, widths and CORDIC angle table for the averaging compass.
// ---------------------------------------------------------------------------
`default_nettype none
package mah_pkg;
  localparam int unsigned SampleW = 16;
  localparam int unsigned AvgW = 20;
  localparam int unsigned HeadW = 16;
  localparam int unsigned CordicSteps = 20;
  localparam int unsigned CordicW = 48;
  localparam int unsigned AngW = 32;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgFlipXy = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDecl = 1'b1;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } lane_ctl_t;

  function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      5'd0: v = 32'sd18432000;
      5'd1: v = 32'sd10881045;
      5'd2: v = 32'sd5749245;
      5'd3: v = 32'sd2918407;
      5'd4: v = 32'sd1464867;
      5'd5: v = 32'sd733147;
      5'd6: v = 32'sd366663;
      5'd7: v = 32'sd183343;
      5'd8: v = 32'sd91673;
      5'd9: v = 32'sd45837;
      5'd10: v = 32'sd22918;
      5'd11: v = 32'sd11459;
      5'd12: v = 32'sd5730;
      5'd13: v = 32'sd2865;
      5'd14: v = 32'sd1432;
      5'd15: v = 32'sd716;
      5'd16: v = 32'sd358;
      5'd17: v = 32'sd179;
      5'd18: v = 32'sd90;
      5'd19: v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

[hw/rtl/mah_ram.sv]
// ---------------------------------------------------------------------------
// mah_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module mah_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8
) (
  input  wire                             clk_i,
  input  wire                             we_i,
  input  wire [$clog2(Depth+1)-1:0]       addr_i,
  input  wire [Width-1:0]                 wdata_i,
  output logic [Width-1:0]                rdata_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  logic [Width-1:0] mem [Depth];
  logic [AW-1:0] a;
  assign a = addr_i[AW-1:0];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[a] <= wdata_i;
    end
    rdata_o <= mem[a];
  end
endmodule
`default_nettype wire

[hw/rtl/mah_div_lane.sv]
// ---------------------------------------------------------------------------
// mah_div_lane
// One averaging lane: restoring divide of a scaled axis sum by the fill count,
// truncated toward zero.
// ---------------------------------------------------------------------------
`default_nettype none
module mah_div_lane #(
  parameter int unsigned SumW = 22,
  parameter int unsigned CntW = 4
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start_i,
  input  wire signed [SumW-1:0]  sum_i,
  input  wire [CntW-1:0]         cnt_i,
  output logic signed [mah_pkg::AvgW-1:0] avg_o,
  output logic                   done_o
);
  import mah_pkg::*;
  localparam int unsigned NW = SumW + 4;
  localparam int unsigned StW = $clog2(NW + 1);

  logic [NW-1:0] num_q, num_d;
  logic [CntW:0] rem_q, rem_d;
  logic [StW-1:0] step_q, step_d;
  logic neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [CntW+1:0] trial;
  logic [NW-1:0] q_signed;

  assign trial = {rem_q, num_q[NW-1]} - {2'b0, cnt_i};

  always_comb begin
    num_d = num_q; rem_d = rem_q; step_d = step_q;
    neg_d = neg_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      num_d = (NW)'($unsigned(sum_i[SumW-1] ? -$signed({{4{sum_i[SumW-1]}}, sum_i})
                                            : $signed({{4{sum_i[SumW-1]}}, sum_i}))) << 4;
      rem_d = '0;
      step_d = '0;
      neg_d = sum_i[SumW-1];
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[CntW+1]) begin
        rem_d = trial[CntW:0];
        num_d = {num_q[NW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[CntW-1:0], num_q[NW-1]};
        num_d = {num_q[NW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign q_signed = neg_q ? -num_q : num_q;
  assign avg_o = q_signed[AvgW-1:0];
  assign done_o = done_q;
endmodule
`default_nettype wire

[hw/rtl/mah_cordic.sv]
// ---------------------------------------------------------------------------
// mah_cordic
// Iterative vectoring CORDIC: atan2(b, a) for b >= 0, in hundredths of a
// degree, one micro-rotation per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module mah_cordic #(
  parameter int unsigned SumW = 22
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  wire signed [SumW-1:0] a_i,
  input  wire signed [SumW:0]   b_i,
  output logic signed [mah_pkg::HeadW:0] ang_o,
  output logic                  done_o
);
  import mah_pkg::*;
  logic signed [CordicW-1:0] cx_q, cx_d, cy_q, cy_d, ax, by;
  logic signed [AngW-1:0] z_q, z_d, zr;
  logic [4:0] i_q, i_d;
  logic busy_q, busy_d, done_q, done_d;

  // shift right by s, rounding toward zero
  function automatic logic signed [CordicW-1:0] shr_trunc(
    input logic signed [CordicW-1:0] v, input logic [4:0] s);
    logic signed [CordicW-1:0] bias;
    bias = v[CordicW-1] ? ((CordicW'(1) << s) - CordicW'(1)) : '0;
    return (v + bias) >>> s;
  endfunction

  assign ax = CordicW'(a_i) <<< 20;
  assign by = CordicW'(b_i) <<< 20;

  always_comb begin
    cx_d = cx_q; cy_d = cy_q; z_d = z_q; i_d = i_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      if (ax < 0) begin
        cx_d = by; cy_d = -ax; z_d = 32'sd36864000;
      end else begin
        cx_d = ax; cy_d = by; z_d = '0;
      end
      i_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cy_q > 0) begin
        cx_d = cx_q + shr_trunc(cy_q, i_q);
        cy_d = cy_q - shr_trunc(cx_q, i_q);
        z_d = z_q + atan_entry(i_q);
      end else begin
        cx_d = cx_q - shr_trunc(cy_q, i_q);
        cy_d = cy_q + shr_trunc(cx_q, i_q);
        z_d = z_q - atan_entry(i_q);
      end
      i_d = i_q + 1'b1;
      if (i_q == 5'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;
    cy_q <= cy_d;
    z_q <= z_d;
  end

  assign zr = (z_q + 32'sd2048) / 32'sd4096;
  assign ang_o = zr[HeadW:0];
  assign done_o = done_q;
endmodule
`default_nettype wire

[hw/rtl/magnetometer_average_heading_top.sv]
// ---------------------------------------------------------------------------
// magnetometer_average_heading_top
// Moving-average compass: per-axis sample ring, three divide lanes and a
// CORDIC heading unit merged into one result word.
// ---------------------------------------------------------------------------
// channel   | handshake          | payload
// in        | in_valid/in_ready  | req_type, x/y/z high and low bytes
// out       | out_valid/out_ready| avg_x/y/z, heading_cdeg, ring_empty
// cfg       | cfg_valid/cfg_ready| cfg_index, cfg_data
// A push steps through a ring read, then a sum update. A read gives its word
// once the SumW+4 steps of the divide lanes and the 20-step CORDIC beside
// them have finished and the output register is free; no word is taken
// before then. Reset clears pointers, sums and config; ring contents stay
// undefined. The result waits in the output register while further words
// are taken; only a read finishing with that word still unaccepted stalls.
// ---------------------------------------------------------------------------
`default_nettype none
module magnetometer_average_heading_top #(
  parameter int unsigned DEPTH = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        req_type_i,
  input  wire [7:0]  x_high_i,
  input  wire [7:0]  x_low_i,
  input  wire [7:0]  y_high_i,
  input  wire [7:0]  y_low_i,
  input  wire [7:0]  z_high_i,
  input  wire [7:0]  z_low_i,
  output logic       out_valid,
  input  wire        out_ready,
  output logic signed [mah_pkg::AvgW-1:0] avg_x_o,
  output logic signed [mah_pkg::AvgW-1:0] avg_y_o,
  output logic signed [mah_pkg::AvgW-1:0] avg_z_o,
  output logic [mah_pkg::HeadW-1:0] heading_cdeg_o,
  output logic       ring_empty_o,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [mah_pkg::CfgIdxW-1:0] cfg_index,
  input  wire [15:0] cfg_data
);
  import mah_pkg::*;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = 16 + $clog2(DEPTH + 1);
  localparam logic [2:0] StIdle = 3'd0, StPushRd = 3'd1, StPushWr = 3'd2,
                         StRead = 3'd3;

  logic [2:0] st_q, st_d;
  logic [CntW-1:0] slot_q, slot_d;
  logic full_q, full_d;
  logic signed [SumW-1:0] sum_q [3];
  logic signed [SumW-1:0] sum_d [3];
  logic flip_q;
  logic signed [15:0] decl_q;
  logic [47:0] smp_q, rd;
  logic [CntW-1:0] cnt;
  logic ram_we;
  logic start;
  logic signed [SumW-1:0] sx, sy;
  logic signed [AvgW-1:0] lane_avg [3];
  logic [2:0] lane_done;
  logic [2:0] lane_seen_q, lane_seen_d;
  logic cor_done, cor_seen_q, cor_seen_d;
  logic signed [HeadW:0] cor_ang;
  logic signed [HeadW+1:0] ang, decl, h;
  logic out_valid_q, out_valid_d;
  logic out_load;
  lane_ctl_t ctl;

  assign cnt = full_q ? CntW'(DEPTH) : slot_q;
  assign in_ready = (st_q == StIdle);
  assign cfg_ready = 1'b1;
  assign ram_we = (st_q == StPushRd);

  mah_ram #(.Width(48), .Depth(DEPTH)) u_ring (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(slot_q),
    .wdata_i(smp_q), .rdata_o(rd)
  );

  assign sx = flip_q ? sum_q[1] : sum_q[0];
  assign sy = flip_q ? sum_q[0] : sum_q[1];
  assign start = in_valid && in_ready && req_type_i;
  assign ctl.start = start;
  assign ctl.busy = (st_q == StRead);
  assign ctl.done = (&(lane_seen_q | lane_done)) && (cor_seen_q || cor_done);
  assign out_load = (st_q == StRead) && ctl.done && (!out_valid_q || out_ready);

  for (genvar k = 0; k < 3; k++) begin : g_lane
    mah_div_lane #(.SumW(SumW), .CntW(CntW)) u_div (
      .clk_i(clk_i), .rst_ni(rst_ni), .start_i(ctl.start),
      .sum_i(k == 0 ? sx : (k == 1 ? sy : sum_q[2])), .cnt_i(cnt),
      .avg_o(lane_avg[k]), .done_o(lane_done[k])
    );
  end

  mah_cordic #(.SumW(SumW)) u_cordic (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(ctl.start),
    .a_i(sy), .b_i(sx[SumW-1] ? -(SumW+1)'(sx) : (SumW+1)'(sx)),
    .ang_o(cor_ang), .done_o(cor_done)
  );

  always_comb begin
    st_d = st_q; slot_d = slot_q; full_d = full_q;
    lane_seen_d = lane_seen_q; cor_seen_d = cor_seen_q;
    out_valid_d = out_valid_q;
    for (int k = 0; k < 3; k++) sum_d[k] = sum_q[k];
    if (out_valid_q && out_ready) out_valid_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (in_valid && in_ready) begin
          st_d = req_type_i ? StRead : StPushRd;
          lane_seen_d = '0;
          cor_seen_d = 1'b0;
        end
      end
      StPushRd: st_d = StPushWr;
      StPushWr: begin
        for (int k = 0; k < 3; k++) begin
          sum_d[k] = sum_q[k] + SumW'($signed(smp_q[47-16*k -: 16]))
                     - (full_q ? SumW'($signed(rd[47-16*k -: 16])) : '0);
        end
        if (slot_q == CntW'(DEPTH - 1)) begin
          slot_d = '0; full_d = 1'b1;
        end else begin
          slot_d = slot_q + 1'b1;
        end
        st_d = StIdle;
      end
      StRead: begin
        lane_seen_d = lane_seen_q | lane_done;
        cor_seen_d = cor_seen_q | cor_done;
        if (out_load) begin
          st_d = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      slot_q <= '0;
      full_q <= 1'b0;
      for (int k = 0; k < 3; k++) sum_q[k] <= '0;
      flip_q <= 1'b0;
      decl_q <= '0;
      lane_seen_q <= '0;
      cor_seen_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      slot_q <= slot_d;
      full_q <= full_d;
      for (int k = 0; k < 3; k++) sum_q[k] <= sum_d[k];
      lane_seen_q <= lane_seen_d;
      cor_seen_q <= cor_seen_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CfgFlipXy: flip_q <= cfg_data[0];
          CfgDecl: decl_q <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      smp_q <= {x_high_i, x_low_i, y_high_i, y_low_i, z_high_i, z_low_i};
    end
  end

  always_comb begin
    ang = '0;
    if (cnt != '0 && (sx != '0 || sy != '0)) begin
      ang = sx[SumW-1] ? (HeadW+2)'(cor_ang) : -(HeadW+2)'(cor_ang);
    end
    decl = (HeadW+2)'(decl_q);
    if (decl_q > 16'sd18000) decl = 18'sd18000;
    if (decl_q < -16'sd18000) decl = -18'sd18000;
    h = ang + decl;
    if (h < 0) h = h + 18'sd36000;
    else if (h > 18'sd36000) h = h - 18'sd36000;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_x_o <= (cnt == '0) ? '0 : lane_avg[0];
      avg_y_o <= (cnt == '0) ? '0 : lane_avg[1];
      avg_z_o <= (cnt == '0) ? '0 : lane_avg[2];
      heading_cdeg_o <= h[HeadW-1:0];
      ring_empty_o <= (cnt == '0);
    end
  end

  assign out_valid = out_valid_q;

  logic unused;
  assign unused = ctl.busy;

  a_out_only_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(st_q) == StRead)
    else $error("result without read");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRead || st_q == StPushRd || st_q == StPushWr) |-> !in_ready)
    else $error("accept while busy");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < CntW'(DEPTH))
    else $error("slot out of range");
endmodule
`default_nettype wire

[tb/sv/magnetometer_average_heading_top_tb.sv]
// ---------------------------------------------------------------------------
// magnetometer_average_heading_top_tb
// Self-checking bench for the moving-average compass. Drives push and read
// words with random gaps on both channels, models the sample ring, per-axis
// sums, means and CORDIC heading, and compares every result word in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module magnetometer_average_heading_top_tb;
  import mah_pkg::*;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;
  localparam int unsigned RING_DEPTH = 8;
  localparam longint PRESCALE = 64'sd1048576;
  localparam longint ANG_ONE = 64'sd4096;

  typedef struct packed {
    logic [AvgW-1:0]  ax;
    logic [AvgW-1:0]  ay;
    logic [AvgW-1:0]  az;
    logic [HeadW-1:0] hd;
    logic             empty;
  } heading_word_t;

  typedef struct {
    logic          req;
    logic [15:0]   x;
    logic [15:0]   y;
    logic [15:0]   z;
    bit            typed;
    heading_word_t word;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type_i = 1'b0;
  logic [7:0] x_high_i = '0, x_low_i = '0, y_high_i = '0, y_low_i = '0;
  logic [7:0] z_high_i = '0, z_low_i = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [AvgW-1:0] avg_x_o, avg_y_o, avg_z_o;
  logic [HeadW-1:0] heading_cdeg_o;
  logic ring_empty_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  magnetometer_average_heading_top #(.DEPTH(RING_DEPTH)) DUT (
    .clk_i, .rst_ni, .in_valid, .in_ready, .req_type_i,
    .x_high_i, .x_low_i, .y_high_i, .y_low_i, .z_high_i, .z_low_i,
    .out_valid, .out_ready, .avg_x_o, .avg_y_o, .avg_z_o, .heading_cdeg_o,
    .ring_empty_o, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // predictor state
  shortint smp_ring[RING_DEPTH][3];
  int unsigned wr_slot = 0;
  bit ring_full = 1'b0;
  longint axis_sum[3] = '{0, 0, 0};
  bit flip_q = 1'b0;
  int decl_q = 0;

  heading_word_t pending_q[$];
  int errors = 0;
  bit tx_fast = 1'b0, rx_fast = 1'b0, long_hold = 1'b0;

  function automatic longint half_plane_angle(longint a, longint b);
    longint cx, cy, z, dx, dy, t;
    cx = a * PRESCALE;
    cy = b * PRESCALE;
    z = 0;
    if (cx < 0) begin
      t = cy;
      cy = -cx;
      cx = t;
      z = 64'sd9000 * ANG_ONE;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = cy / (longint'(1) << i);
      dy = cx / (longint'(1) << i);
      if (cy > 0) begin
        cx += dx; cy -= dy; z += longint'(atan_entry(i[4:0]));
      end else begin
        cx -= dx; cy += dy; z -= longint'(atan_entry(i[4:0]));
      end
    end
    return (z + ANG_ONE / 2) / ANG_ONE;
  endfunction

  function automatic heading_word_t average_heading();
    heading_word_t w;
    longint cnt, sx, sy, sz, ax, ay, az, ang, h, d, a;
    cnt = ring_full ? RING_DEPTH : wr_slot;
    sx = axis_sum[0]; sy = axis_sum[1]; sz = axis_sum[2];
    ax = 0; ay = 0; az = 0; ang = 0;
    if (flip_q) begin
      a = sx; sx = sy; sy = a;
    end
    if (cnt > 0) begin
      ax = (sx * 16) / cnt;
      ay = (sy * 16) / cnt;
      az = (sz * 16) / cnt;
      if (sx != 0 || sy != 0) begin
        a = half_plane_angle(sy, (sx < 0) ? -sx : sx);
        ang = (sx >= 0) ? -a : a;
      end
    end
    d = decl_q;
    if (d > 18000) d = 18000;
    if (d < -18000) d = -18000;
    h = ang + d;
    if (h < 0) h += 36000;
    if (h > 36000) h -= 36000;
    w.ax = ax[AvgW-1:0];
    w.ay = ay[AvgW-1:0];
    w.az = az[AvgW-1:0];
    w.hd = h[HeadW-1:0];
    w.empty = (cnt == 0);
    return w;
  endfunction

  function automatic void store_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    shortint s[3];
    s[0] = x; s[1] = y; s[2] = z;
    for (int k = 0; k < 3; k++) begin
      if (ring_full) axis_sum[k] -= smp_ring[wr_slot][k];
      smp_ring[wr_slot][k] = s[k];
      axis_sum[k] += s[k];
    end
    wr_slot++;
    if (wr_slot >= RING_DEPTH) begin
      wr_slot = 0;
      ring_full = 1'b1;
    end
  endfunction

  task automatic send_word(logic req, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           bit typed, heading_word_t tw);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type_i <= req;
    {x_high_i, x_low_i} <= x;
    {y_high_i, y_low_i} <= y;
    {z_high_i, z_low_i} <= z;
    do @(posedge clk_i); while (!in_ready);
    if (req == REQ_PUSH) store_sample(x, y, z);
    else pending_q.push_back(typed ? tw : average_heading());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgFlipXy) flip_q = data[0];
    else decl_q = int'($signed(data));
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_value(int mode);
    logic [15:0] v;
    case (mode)
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(0, 200) - 100);
      default: begin
        case ($urandom_range(0, 4))
          0: v = 16'h7fff;
          1: v = 16'h8000;
          2: v = 16'h0000;
          3: v = 16'hffff;
          default: v = 16'h0001;
        endcase
      end
    endcase
    return v;
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = rx_fast ? 0 : $urandom_range(0, 10);
      if (long_hold) begin
        long_hold = 1'b0;
        n = 400;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  always @(posedge clk_i) begin
    heading_word_t got, want;
    if (rst_ni && out_valid && out_ready) begin
      got = '{avg_x_o, avg_y_o, avg_z_o, heading_cdeg_o, ring_empty_o};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.ax !== want.ax) begin
          $display("%0t: avg_x exp %h got %h", $time, want.ax, got.ax); errors++;
        end
        if (got.ay !== want.ay) begin
          $display("%0t: avg_y exp %h got %h", $time, want.ay, got.ay); errors++;
        end
        if (got.az !== want.az) begin
          $display("%0t: avg_z exp %h got %h", $time, want.az, got.az); errors++;
        end
        if (got.hd !== want.hd) begin
          $display("%0t: heading exp %0d got %0d", $time, want.hd, got.hd); errors++;
        end
        if (got.empty !== want.empty) begin
          $display("%0t: ring_empty exp %b got %b", $time, want.empty, got.empty); errors++;
        end
      end
    end
  end

  stim_row_t rows[$];
  heading_word_t nil_word;

  initial begin
    int mode, r;
    logic [15:0] xv;
    logic flip_set[10];
    logic [15:0] decl_set[10];
    flip_set = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
    decl_set = '{16'd0, 16'd0, 16'd18000, -16'sd18000, 16'h7fff,
                 16'h8000, 16'd9000, 16'd0, 16'd0, 16'd0};
    nil_word = '0;
    rows.push_back('{REQ_READ, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                     '{20'h0, 20'h0, 20'h0, 16'd0, 1'b1}});
    rows.push_back('{REQ_PUSH, 16'h0000, 16'h0000, 16'h0000, 1'b0, nil_word});
    rows.push_back('{REQ_READ, 16'hffff, 16'hffff, 16'hffff, 1'b0, nil_word});
    rows.push_back('{REQ_PUSH, 16'h0000, 16'h8000, 16'h7fff, 1'b0, nil_word});
    rows.push_back('{REQ_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, nil_word});
    rows.push_back('{REQ_PUSH, 16'h7fff, 16'h7fff, 16'h8000, 1'b0, nil_word});
    rows.push_back('{REQ_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, nil_word});
    rows.push_back('{REQ_PUSH, 16'h8000, 16'h0000, 16'hffff, 1'b0, nil_word});
    rows.push_back('{REQ_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, nil_word});
    rows.push_back('{REQ_PUSH, 16'hffff, 16'h0001, 16'h0001, 1'b0, nil_word});
    for (int i = 0; i < 5; i++)
      rows.push_back('{REQ_PUSH, 16'h8000, 16'h8000, 16'h8000, 1'b0, nil_word});
    rows.push_back('{REQ_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, nil_word});
    rows.push_back('{REQ_PUSH, 16'h1234, 16'habcd, 16'h5a5a, 1'b0, nil_word});
    rows.push_back('{REQ_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, nil_word});
    rows.push_back('{REQ_PUSH, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, nil_word});
    rows.push_back('{REQ_READ, 16'h0000, 16'h0000, 16'h0000, 1'b0, nil_word});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_word(rows[i].req, rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].word);

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      cfg_write(CfgFlipXy, {15'd0, (ph >= 7) ? 1'($urandom) : flip_set[ph]});
      cfg_write(CfgDecl, (ph >= 7) ? 16'($urandom_range(0, 40000) - 20000) : decl_set[ph]);
      tx_fast = (ph == 4);
      rx_fast = (ph == 5);
      mode = ph % 3;
      if (ph == 2) begin
        long_hold = 1'b1;
        for (int i = 0; i < 24; i++) begin
          tx_fast = 1'b1;
          send_word(REQ_READ, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, nil_word);
        end
        tx_fast = 1'b0;
      end
      for (int i = 0; i < 95; i++) begin
        if (ph == 3 && i == 50) drain();
        r = $urandom_range(0, 99);
        if (r < 55) begin
          xv = (ph == 6) ? 16'h0000 : pick_value(mode);
          send_word(REQ_PUSH, xv, pick_value(mode), pick_value(mode), 1'b0, nil_word);
        end else begin
          send_word(REQ_READ, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, nil_word);
        end
      end
    end
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
